// ----- hw/rtl/siph_pkg.sv -----
// Shared types for the SipHash-2-4 unit: the work-queue entry passed from
// the front end to the round engine. No dependencies.
package siph_pkg;

  // Kind of work one queue entry asks of the round engine.
  typedef enum logic [1:0] {
    OP_ABSORB       = 2'd0,  // compress one full word
    OP_FINAL        = 2'd1,  // compress the tail block, then finalize
    OP_ABSORB_FINAL = 2'd2   // full last word, then tail block, then finalize
  } op_e;

  typedef struct packed {
    op_e         kind;
    logic        first;  // first entry of a message: lanes load from the key
    logic [63:0] word;   // message word (unused by OP_FINAL)
    logic [63:0] tail;   // tail block with length byte (unused by OP_ABSORB)
  } entry_t;

endpackage

// ----- hw/rtl/siph_in_if.sv -----
// Message input channel: valid/ready handshake carrying one message word.
// Standalone, no dependencies.
interface siph_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        end_of_message;

  modport source (output valid, output data_word, output byte_count,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_word, input byte_count,
                  input end_of_message, output ready);
endinterface

// ----- hw/rtl/siph_out_if.sv -----
// Hash output channel: valid/ready handshake carrying one 64-bit hash.
// Standalone, no dependencies.
interface siph_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// ----- hw/rtl/siph_front.sv -----
// Front end: accepts message words, tracks message length, builds tail blocks
// and classifies each word into a queue entry. Uses siph_pkg and siph_in_if.
module siph_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  siph_in_if.sink           msg_in,
  input  logic              full_i,
  output logic              push_o,
  output siph_pkg::entry_t  entry_o
);

  localparam logic [3:0] FullBytes = 4'd8;

  logic [7:0]  len_q, len_d;
  logic        busy_q, busy_d;
  logic [3:0]  cnt;
  logic [7:0]  len_word, len_part;
  logic [63:0] masked;

  assign msg_in.ready = !full_i;
  assign push_o       = msg_in.valid && !full_i;

  // Counts above eight saturate.
  assign cnt      = (msg_in.byte_count > FullBytes) ? FullBytes : msg_in.byte_count;
  assign len_word = len_q + 8'd8;
  assign len_part = len_q + {4'b0000, cnt};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < cnt) ? msg_in.data_word[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    entry_o.first = !busy_q;
    entry_o.word  = msg_in.data_word;
    entry_o.kind  = siph_pkg::OP_ABSORB;
    entry_o.tail  = '0;
    len_d         = len_q;
    busy_d        = busy_q;
    if (!msg_in.end_of_message) begin
      len_d = len_word;
    end else if (cnt == FullBytes) begin
      entry_o.kind = siph_pkg::OP_ABSORB_FINAL;
      entry_o.tail = {len_word, 56'd0};
    end else begin
      entry_o.kind = siph_pkg::OP_FINAL;
      entry_o.tail = {len_part, masked[55:0]};
    end
    if (push_o) begin
      if (msg_in.end_of_message) begin
        len_d  = '0;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else begin
      len_d  = len_q;
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ----- hw/rtl/siph_queue.sv -----
// Work queue between front end and round engine: a small register FIFO.
// Uses siph_pkg.
module siph_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  siph_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output siph_pkg::entry_t  entry_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  siph_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/siph_back.sv -----
// Round engine: one SipRound per cycle on the four lanes unless stalled; runs
// compression and finalization per queue entry. Uses siph_pkg, siph_out_if.
module siph_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [63:0]       key_low_i,
  input  logic [63:0]       key_high_i,
  input  logic              entry_valid_i,
  input  siph_pkg::entry_t  entry_i,
  output logic              pop_o,
  siph_out_if.source        hash_out
);

  localparam logic [63:0] IvA       = 64'h736f6d6570736575;
  localparam logic [63:0] IvB       = 64'h646f72616e646f6d;
  localparam logic [63:0] IvC       = 64'h6c7967656e657261;
  localparam logic [63:0] IvD       = 64'h7465646279746573;
  localparam logic [63:0] FinalMark = 64'h00000000000000ff;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // pop an entry, first compression round
    ST_R2   = 4'b0010,  // second compression round, fold word into lane a
    ST_T1   = 4'b0100,  // first round of the tail block after a full last word
    ST_F    = 4'b1000   // four finalization rounds
  } state_e;

  function automatic lanes_t sip_round(lanes_t v);
    lanes_t r;
    r   = v;
    r.a = r.a + r.b;
    r.c = r.c + r.d;
    r.b = {r.b[50:0], r.b[63:51]};
    r.d = {r.d[47:0], r.d[63:48]};
    r.b = r.b ^ r.a;
    r.d = r.d ^ r.c;
    r.a = {r.a[31:0], r.a[63:32]};
    r.c = r.c + r.b;
    r.a = r.a + r.d;
    r.b = {r.b[46:0], r.b[63:47]};
    r.d = {r.d[42:0], r.d[63:43]};
    r.b = r.b ^ r.c;
    r.d = r.d ^ r.a;
    r.c = {r.c[31:0], r.c[63:32]};
    return r;
  endfunction

  state_e          state_q, state_d;
  lanes_t          lanes_q, lanes_d;
  lanes_t          base, rin, rout;
  siph_pkg::op_e   kind_q, kind_d;
  logic [63:0]     m_q, m_d, tail_q, tail_d;
  logic [63:0]     m_sel, pre_d, post_a, post_c;
  logic [1:0]      fcnt_q, fcnt_d;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     hash_q, hash_d;

  assign hash_out.valid      = out_valid_q;
  assign hash_out.hash_value = hash_q;

  always_comb begin
    state_d     = state_q;
    lanes_d     = lanes_q;
    kind_d      = kind_q;
    m_d         = m_q;
    tail_d      = tail_q;
    fcnt_d      = fcnt_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !hash_out.ready;
    pop_o       = 1'b0;
    base        = lanes_q;
    m_sel       = m_q;
    pre_d       = '0;
    post_a      = '0;
    post_c      = '0;

    // Operand selection for this cycle's round
    if (state_q == ST_IDLE) begin
      if (entry_i.first) begin
        base = '{a: key_low_i ^ IvA, b: key_high_i ^ IvB,
                 c: key_low_i ^ IvC, d: key_high_i ^ IvD};
      end
      m_sel = (entry_i.kind == siph_pkg::OP_FINAL) ? entry_i.tail : entry_i.word;
      pre_d = m_sel;
    end else if (state_q == ST_R2) begin
      post_a = m_q;
      if (kind_q == siph_pkg::OP_FINAL) begin
        post_c = FinalMark;
      end
    end else if (state_q == ST_T1) begin
      pre_d = m_q;
    end

    rin   = base;
    rin.d = rin.d ^ pre_d;
    rout  = sip_round(rin);
    rout.a = rout.a ^ post_a;
    rout.c = rout.c ^ post_c;

    case (state_q)
      ST_IDLE: begin
        if (entry_valid_i) begin
          pop_o   = 1'b1;
          lanes_d = rout;
          m_d     = m_sel;
          tail_d  = entry_i.tail;
          kind_d  = entry_i.kind;
          state_d = ST_R2;
        end
      end
      ST_R2: begin
        lanes_d = rout;
        case (kind_q)
          siph_pkg::OP_ABSORB: begin
            state_d = ST_IDLE;
          end
          siph_pkg::OP_ABSORB_FINAL: begin
            m_d     = tail_q;
            kind_d  = siph_pkg::OP_FINAL;
            state_d = ST_T1;
          end
          default: begin
            fcnt_d  = '0;
            state_d = ST_F;
          end
        endcase
      end
      ST_T1: begin
        lanes_d = rout;
        state_d = ST_R2;
      end
      ST_F: begin
        if (fcnt_q != 2'd3) begin
          lanes_d = rout;
          fcnt_d  = fcnt_q + 2'd1;
        end else if (!out_valid_q || hash_out.ready) begin
          // last round; holds here while the output register is occupied
          lanes_d     = rout;
          hash_d      = rout.a ^ rout.b ^ rout.c ^ rout.d;
          out_valid_d = 1'b1;
          fcnt_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    m_q     <= m_d;
    tail_q  <= tail_d;
    hash_q  <= hash_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= siph_pkg::OP_ABSORB;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_absorb_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_R2 && kind_q == siph_pkg::OP_ABSORB) |=> state_q == ST_IDLE)
    else $error("absorb did not finish after two rounds");

  a_fcnt_only_in_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_F) |-> fcnt_q == 2'd0)
    else $error("finalization counter left nonzero");

  a_hash_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_F)
    else $error("hash written outside finalization");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE && entry_valid_i))
    else $error("queue popped while busy or empty");
`endif

endmodule

// ----- hw/rtl/siphash_2_4_keyed_hash_unit.sv -----
// SipHash-2-4 keyed hash unit, top level: key registers, front end, work
// queue and round engine. Uses siph_pkg, siph_in_if, siph_out_if.
//
// Computes the 64-bit SipHash-2-4 of a message under the 128-bit key held
// in key_low (index 0) and key_high (index 1). Message words arrive on
// msg_in, little-endian, first byte in bits 7:0; each non-last word carries
// eight bytes, the last word (end_of_message set) carries byte_count bytes
// (0..8, larger counts read as 8). An empty message is one last word with
// count 0. The hash leaves on hash_out. Timing: the round engine does one
// SipRound per cycle: two compression rounds per word, four finalization
// rounds after the last, and two more for the tail block when the last
// word is full. The front end takes one word per cycle while the work
// queue (QueueDepth entries) has room, and the engine keeps running while
// a finished hash waits in the output register; it stalls only at the end
// of the next message if that hash is still not taken. The key is sampled
// when the first word of a message reaches the round engine, so a key
// write affects the next message. No clearing pass is needed after reset.
module siphash_2_4_keyed_hash_unit #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  siph_in_if.sink     msg_in,
  siph_out_if.source  hash_out
);

  // Register indexes
  localparam logic RegKeyLow  = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  logic [63:0]       key_low_q, key_high_q;
  logic              full, push, pop, q_valid;
  siph_pkg::entry_t  push_entry, head_entry;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeyLow:  key_low_q  <= cfg_data_i;
        RegKeyHigh: key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: length tracking, tail block build, classification
  siph_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .msg_in  (msg_in),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Decouples word intake from the multi-cycle rounds
  siph_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  // Round engine with output register
  siph_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_low_i     (key_low_q),
    .key_high_i    (key_high_q),
    .entry_valid_i (q_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .hash_out      (hash_out)
  );

endmodule
